// ----- src/bpl_pkg.sv -----
// Shared types and constants for the bounded positional list unit.
// Operation codes, status codes and the engine command/response structs.
// No dependencies.
package bpl_pkg;

  // Default sizing of the list
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Request operation codes
  typedef enum logic [3:0] {
    KIND_ADD_FRONT    = 4'd0,
    KIND_ADD_BACK     = 4'd1,
    KIND_INSERT_AT    = 4'd2,
    KIND_REMOVE_FRONT = 4'd3,
    KIND_REMOVE_BACK  = 4'd4,
    KIND_REMOVE_AT    = 4'd5,
    KIND_REMOVE_VALUE = 4'd6,
    KIND_READ         = 4'd7,
    KIND_CONTAINS     = 4'd8
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  // Engine operations
  typedef enum logic [2:0] {
    OP_INSERT      = 3'd0,
    OP_REMOVE      = 3'd1,
    OP_READ        = 3'd2,
    OP_FIND        = 3'd3,
    OP_FIND_REMOVE = 3'd4
  } eng_op_t;

  // Command from the request decoder to the engine
  typedef struct packed {
    logic    start;
    eng_op_t op;
  } eng_cmd_t;

  // Response from the engine
  typedef struct packed {
    logic done;
    logic hit;
  } eng_rsp_t;

endpackage

// ----- src/bpl_engine.sv -----
// Entry store and shift/scan sequencer of the bounded positional list.
// One single-port-write, registered-read memory; one index adder steps it.
// Depends on bpl_pkg.
module bpl_engine #(
  parameter int  CAPACITY   = bpl_pkg::CAPACITY_DEF,
  parameter int  DATA_WIDTH = bpl_pkg::DATA_WIDTH_DEF,
  localparam int AW         = $clog2(CAPACITY),
  localparam int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpl_pkg::eng_cmd_t     cmd,
  input  logic [CW-1:0]         cnt,
  input  logic [CW-1:0]         at,
  input  logic [DATA_WIDTH-1:0] word,
  output bpl_pkg::eng_rsp_t     rsp,
  output logic [DATA_WIDTH-1:0] res
);
  import bpl_pkg::*;

  typedef enum logic [9:0] {
    ES_IDLE    = 10'b0000000001,
    ES_INS_RD  = 10'b0000000010,
    ES_INS_WR  = 10'b0000000100,
    ES_GET_RD  = 10'b0000001000,
    ES_GET_CAP = 10'b0000010000,
    ES_SHF_RD  = 10'b0000100000,
    ES_SHF_WR  = 10'b0001000000,
    ES_SCN_RD  = 10'b0010000000,
    ES_SCN_CMP = 10'b0100000000,
    ES_DONE    = 10'b1000000000
  } eng_state_t;

  eng_state_t            st_r, st_nxt;
  logic [CW-1:0]         i_r, i_nxt, i_step;
  logic                  step_down;
  logic                  hit_r, hit_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;

  // Shared index adder: count down while opening a gap, up otherwise
  assign step_down = (st_r == ES_INS_RD) || (st_r == ES_INS_WR);
  assign i_step    = i_r + (step_down ? {CW{1'b1}} : CW'(1));

  // Sequencer
  always_comb begin
    st_nxt  = st_r;
    i_nxt   = i_r;
    hit_nxt = hit_r;
    res_nxt = res_r;
    we      = 1'b0;
    waddr   = i_r[AW-1:0];
    wdata   = rdata_r;
    raddr   = i_r[AW-1:0];
    case (st_r)
      ES_IDLE: begin
        if (cmd.start) begin
          hit_nxt = 1'b0;
          case (cmd.op)
            OP_INSERT: begin
              i_nxt  = cnt;
              st_nxt = ES_INS_RD;
            end
            OP_REMOVE, OP_READ: begin
              st_nxt = ES_GET_RD;
            end
            OP_FIND, OP_FIND_REMOVE: begin
              i_nxt  = '0;
              st_nxt = ES_SCN_RD;
            end
            default: st_nxt = ES_DONE;
          endcase
        end
      end
      // Open the gap from the back, one entry per read/write pair
      ES_INS_RD: begin
        if (i_r == at) begin
          we     = 1'b1;
          waddr  = at[AW-1:0];
          wdata  = word;
          st_nxt = ES_DONE;
        end else begin
          raddr  = i_step[AW-1:0];
          st_nxt = ES_INS_WR;
        end
      end
      ES_INS_WR: begin
        we     = 1'b1;
        i_nxt  = i_step;
        st_nxt = ES_INS_RD;
      end
      // Fetch the addressed entry
      ES_GET_RD: begin
        raddr  = at[AW-1:0];
        st_nxt = ES_GET_CAP;
      end
      ES_GET_CAP: begin
        res_nxt = rdata_r;
        i_nxt   = at;
        st_nxt  = (cmd.op == OP_READ) ? ES_DONE : ES_SHF_RD;
      end
      // Close the gap towards the front
      ES_SHF_RD: begin
        if (i_step >= cnt) begin
          st_nxt = ES_DONE;
        end else begin
          raddr  = i_step[AW-1:0];
          st_nxt = ES_SHF_WR;
        end
      end
      ES_SHF_WR: begin
        we     = 1'b1;
        i_nxt  = i_step;
        st_nxt = ES_SHF_RD;
      end
      // Scan from the front for the first match
      ES_SCN_RD: begin
        if (i_r == cnt) begin
          st_nxt = ES_DONE;
        end else begin
          st_nxt = ES_SCN_CMP;
        end
      end
      ES_SCN_CMP: begin
        if (rdata_r == word) begin
          hit_nxt = 1'b1;
          res_nxt = rdata_r;
          st_nxt  = (cmd.op == OP_FIND_REMOVE) ? ES_SHF_RD : ES_DONE;
        end else begin
          i_nxt  = i_step;
          st_nxt = ES_SCN_RD;
        end
      end
      ES_DONE: begin
        st_nxt = ES_IDLE;
      end
      default: st_nxt = ES_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ES_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
  end

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rsp = '{done: (st_r == ES_DONE), hit: hit_r};
  assign res = res_r;

  // A new command only arrives while the sequencer is free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> st_r == ES_IDLE)
    else $error("engine started while busy");

  // Writes stay inside the store
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> int'(waddr) < CAPACITY)
    else $error("engine write beyond capacity");

  // The working index never passes the entry count
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ES_IDLE && st_r != ES_DONE) |-> i_r <= cnt)
    else $error("engine index beyond count");

endmodule

// ----- src/bounded_positional_list_unit.sv -----
// Bounded positional list: top level with request decode, count and result register.
// A request that needs no engine pass (full, empty, range, unknown kind) goes straight to the
// result register; read, insert and remove wait for the engine, insert and remove moving the
// entries behind the position, and search scans at most every entry held (remove value included).
// Throughput: one request at a time; the next transfer is taken in the cycle out_valid rises,
// later while a result is stalled. Reset (synchronous, rst_n low) empties the list; no clearing pass.
module bounded_positional_list_unit #(
  parameter int  CAPACITY   = bpl_pkg::CAPACITY_DEF,
  parameter int  DATA_WIDTH = bpl_pkg::DATA_WIDTH_DEF,
  localparam int CW         = $clog2(CAPACITY + 1),
  localparam int PW         = (CW > 5) ? CW : 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_kind,
  input  logic [4:0]       in_position,
  input  logic [31:0]      in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_result_value,
  output bpl_pkg::status_t out_status,
  output logic             out_found,
  output logic [4:0]       out_entry_count
);
  import bpl_pkg::*;

  typedef enum logic [2:0] {
    TS_IDLE = 3'b001,
    TS_WAIT = 3'b010,
    TS_HOLD = 3'b100
  } top_state_t;

  top_state_t            st_r, st_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  start_r, start_nxt;
  logic [3:0]            kind_r, kind_nxt;
  eng_op_t               op_r, op_nxt;
  logic [CW-1:0]         at_r, at_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [DATA_WIDTH-1:0] pend_value_r, pend_value_nxt;
  status_t               pend_status_r, pend_status_nxt;
  logic                  pend_found_r, pend_found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_value_r;
  status_t               out_status_r;
  logic                  out_found_r;
  logic [4:0]            out_count_r;
  logic                  out_load;

  // Decode signals
  logic                  is_full, is_empty, pos_ge_cnt, pos_ge_last;
  logic [CW-1:0]         last_idx;
  logic                  dec_engine;
  eng_op_t               dec_op;
  logic [CW-1:0]         dec_at;
  status_t               dec_status;

  eng_cmd_t              eng_cmd;
  eng_rsp_t              eng_rsp;
  logic [DATA_WIDTH-1:0] eng_res;

  assign in_stall = (st_r != TS_IDLE);

  // Classify the incoming request against the current count
  assign is_full     = (count_r == CW'(CAPACITY));
  assign is_empty    = (count_r == '0);
  assign last_idx    = count_r - CW'(1);
  assign pos_ge_cnt  = PW'(in_position) >= PW'(count_r);
  assign pos_ge_last = PW'(in_position) >= PW'(last_idx);

  always_comb begin
    dec_engine = 1'b0;
    dec_op     = OP_READ;
    dec_at     = '0;
    dec_status = STAT_OK;
    case (in_kind)
      KIND_ADD_FRONT, KIND_ADD_BACK, KIND_INSERT_AT: begin
        if (is_full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_engine = 1'b1;
          dec_op     = OP_INSERT;
          if (in_kind == KIND_ADD_FRONT) begin
            dec_at = '0;
          end else if (in_kind == KIND_ADD_BACK || pos_ge_cnt) begin
            dec_at = count_r;
          end else begin
            dec_at = CW'(in_position);
          end
        end
      end
      KIND_REMOVE_FRONT, KIND_REMOVE_BACK, KIND_REMOVE_AT: begin
        if (is_empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_engine = 1'b1;
          dec_op     = OP_REMOVE;
          if (in_kind == KIND_REMOVE_FRONT) begin
            dec_at = '0;
          end else if (in_kind == KIND_REMOVE_BACK || pos_ge_last) begin
            dec_at = last_idx;
          end else begin
            dec_at = CW'(in_position);
          end
        end
      end
      KIND_REMOVE_VALUE: begin
        if (is_empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_engine = 1'b1;
          dec_op     = OP_FIND_REMOVE;
        end
      end
      KIND_READ: begin
        if (is_empty) begin
          dec_status = STAT_EMPTY;
        end else if (pos_ge_cnt) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_engine = 1'b1;
          dec_op     = OP_READ;
          dec_at     = CW'(in_position);
        end
      end
      KIND_CONTAINS: begin
        dec_engine = 1'b1;
        dec_op     = OP_FIND;
      end
      default: ;
    endcase
  end

  // Request sequencing and result assembly
  always_comb begin
    st_nxt          = st_r;
    count_nxt       = count_r;
    start_nxt       = 1'b0;
    kind_nxt        = kind_r;
    op_nxt          = op_r;
    at_nxt          = at_r;
    word_nxt        = word_r;
    pend_value_nxt  = pend_value_r;
    pend_status_nxt = pend_status_r;
    pend_found_nxt  = pend_found_r;
    case (st_r)
      TS_IDLE: begin
        if (in_valid) begin
          kind_nxt        = in_kind;
          op_nxt          = dec_op;
          at_nxt          = dec_at;
          word_nxt        = DATA_WIDTH'(in_value);
          pend_value_nxt  = '0;
          pend_status_nxt = dec_status;
          pend_found_nxt  = 1'b0;
          if (dec_engine) begin
            start_nxt = 1'b1;
            st_nxt    = TS_WAIT;
          end else begin
            st_nxt = TS_HOLD;
          end
        end
      end
      TS_WAIT: begin
        if (eng_rsp.done) begin
          st_nxt = TS_HOLD;
          case (kind_r)
            KIND_ADD_FRONT, KIND_ADD_BACK, KIND_INSERT_AT: begin
              count_nxt = count_r + CW'(1);
            end
            KIND_REMOVE_FRONT, KIND_REMOVE_BACK, KIND_REMOVE_AT: begin
              count_nxt      = count_r - CW'(1);
              pend_value_nxt = eng_res;
            end
            KIND_REMOVE_VALUE: begin
              if (eng_rsp.hit) begin
                count_nxt      = count_r - CW'(1);
                pend_value_nxt = eng_res;
                pend_found_nxt = 1'b1;
              end else begin
                pend_status_nxt = STAT_NOTFOUND;
              end
            end
            KIND_READ: begin
              pend_value_nxt = eng_res;
            end
            KIND_CONTAINS: begin
              pend_found_nxt = eng_rsp.hit;
            end
            default: ;
          endcase
        end
      end
      TS_HOLD: begin
        if (out_load) begin
          st_nxt = TS_IDLE;
        end
      end
      default: st_nxt = TS_IDLE;
    endcase
  end

  // Result register: load when empty or being drained
  assign out_load = (st_r == TS_HOLD) && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= TS_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    op_r          <= op_nxt;
    at_r          <= at_nxt;
    word_r        <= word_nxt;
    pend_value_r  <= pend_value_nxt;
    pend_status_r <= pend_status_nxt;
    pend_found_r  <= pend_found_nxt;
    if (out_load) begin
      out_value_r  <= 32'(pend_value_r);
      out_status_r <= pend_status_r;
      out_found_r  <= pend_found_r;
      out_count_r  <= 5'(count_r);
    end
  end

  assign eng_cmd = '{start: start_r, op: op_r};

  bpl_engine #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (eng_cmd),
    .cnt   (count_r),
    .at    (at_r),
    .word  (word_r),
    .rsp   (eng_rsp),
    .res   (eng_res)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_entry_count  = out_count_r;

  // The count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY)
    else $error("entry count beyond capacity");

  // Engine completion only while a request waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    eng_rsp.done |-> st_r == TS_WAIT)
    else $error("engine completion outside wait");

  // The count moves only on engine completion
  a_count_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> $past(eng_rsp.done))
    else $error("count changed without engine completion");

  // A held result is not dropped while the output is stalled
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == TS_HOLD && out_valid_r && out_stall) |=> st_r == TS_HOLD)
    else $error("result left hold while output stalled");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for bounded_positional_list_unit: a directed table, then random traffic.
// Every result is checked against a behavioural list predictor held in this file, or against a typed-in table result.
// Depends on bpl_pkg and the bounded_positional_list_unit RTL.
module tb_top;
  import bpl_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 800;
  // Drain wait covers the longest request, a full shift or search
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

  typedef struct {
    logic [31:0] word;
    status_t     status;
    logic        found;
    logic [4:0]  count;
  } list_result_t;

  typedef struct {
    logic [3:0]   kind;
    logic [4:0]   pos;
    logic [31:0]  value;
    int           reps;
    bit           known;
    list_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_kind = '0;
  logic [4:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_value;
  status_t     out_status;
  logic        out_found;
  logic [4:0]  out_entry_count;

  // Predictor state and result bookkeeping
  logic [31:0]  list_words [DEPTH];
  int           list_len = 0;
  list_result_t pending_results [$];
  plan_row_t    plan [$];
  int           mismatches = 0;
  bit           quiet = 1'b0;
  int           hold_left = 0;

  bounded_positional_list_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_entry_count  (out_entry_count)
  );

  always #4 clk = ~clk;

  // Idle cycles before the next transfer, or stall length after a result; none during quiet stretches
  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  // Index of the first entry equal to word, or the length when absent
  function automatic int find_word(logic [31:0] word);
    int i;
    for (i = 0; i < list_len; i++)
      if (list_words[i] == word) return i;
    return list_len;
  endfunction

  // Take out one entry and close the gap behind it
  function automatic logic [31:0] take_word(int at);
    logic [31:0] word;
    int i;
    word = list_words[at];
    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
    return word;
  endfunction

  // Apply one request to the predicted list and return its result
  function automatic list_result_t apply_request(logic [3:0] kind, logic [4:0] pos,
                                                 logic [31:0] word);
    list_result_t r;
    int at;
    int i;
    r.word = '0;
    r.status = STAT_OK;
    r.found = 1'b0;
    case (kind)
      KIND_ADD_FRONT, KIND_ADD_BACK, KIND_INSERT_AT: begin
        if (list_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (kind == KIND_ADD_FRONT) at = 0;
          else if (kind == KIND_ADD_BACK || pos >= list_len) at = list_len;
          else at = pos;
          for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
          list_words[at] = word;
          list_len++;
        end
      end
      KIND_REMOVE_FRONT, KIND_REMOVE_BACK, KIND_REMOVE_AT: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (kind == KIND_REMOVE_FRONT) at = 0;
          else if (kind == KIND_REMOVE_BACK || pos >= list_len - 1) at = list_len - 1;
          else at = pos;
          r.word = take_word(at);
        end
      end
      KIND_REMOVE_VALUE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          at = find_word(word);
          if (at < list_len) begin
            r.word = take_word(at);
            r.found = 1'b1;
          end else begin
            r.status = STAT_NOTFOUND;
          end
        end
      end
      KIND_READ: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else if (pos >= list_len) r.status = STAT_RANGE;
        else r.word = list_words[pos];
      end
      KIND_CONTAINS: r.found = (find_word(word) < list_len);
      default: ;
    endcase
    r.count = 5'(list_len);
    return r;
  endfunction

  // Queue the expectation, then present the request until the transfer
  task automatic issue_request(logic [3:0] kind, logic [4:0] pos, logic [31:0] value,
                               bit known, list_result_t want);
    list_result_t predicted;
    int gap;
    predicted = apply_request(kind, pos, value);
    pending_results.push_back(known ? want : predicted);
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Table row checked against the predictor
  function automatic void plan_checked(logic [3:0] kind, logic [4:0] pos, logic [31:0] value,
                                       int reps);
    plan_row_t row;
    row.kind = kind;
    row.pos = pos;
    row.value = value;
    row.reps = reps;
    row.known = 1'b0;
    row.want = '{word: '0, status: STAT_OK, found: 1'b0, count: '0};
    plan.push_back(row);
  endfunction

  // Table row with its result typed in
  function automatic void plan_known(logic [3:0] kind, logic [4:0] pos, logic [31:0] value,
                                     logic [31:0] word, status_t status, logic found,
                                     logic [4:0] count);
    plan_row_t row;
    row.kind = kind;
    row.pos = pos;
    row.value = value;
    row.reps = 1;
    row.known = 1'b1;
    row.want = '{word: word, status: status, found: found, count: count};
    plan.push_back(row);
  endfunction

  // Accept results with random stalls and check each against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    int h;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: value %h status %0d found %0d count %0d", $time,
                 out_result_value, out_status, out_found, out_entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.word) begin
          mismatches++;
          $display("%0t result_value mismatch: expected %h actual %h", $time, want.word,
                   out_result_value);
        end
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t status mismatch: expected %0d actual %0d", $time, want.status,
                   out_status);
        end
        if (out_found !== want.found) begin
          mismatches++;
          $display("%0t found mismatch: expected %0d actual %0d", $time, want.found,
                   out_found);
        end
        if (out_entry_count !== want.count) begin
          mismatches++;
          $display("%0t entry_count mismatch: expected %0d actual %0d", $time, want.count,
                   out_entry_count);
        end
      end
      h = idle_draw();
      if (h > 0) begin
        out_stall <= 1'b1;
        hold_left <= h - 1;
      end
    end else if (out_stall) begin
      if (hold_left == 0) out_stall <= 1'b0;
      else hold_left <= hold_left - 1;
    end
  end

  // Stimulus: directed table, then random phases that alternately fill and drain
  initial begin
    logic [31:0] word_pool [8];
    logic [3:0]  kind;
    logic [4:0]  pos;
    logic [31:0] value;
    int          ins_pct;
    int          r;
    int          n;
    int          k;
    int          waited;

    // Empty list: every remove and read reports empty, contains misses, an unknown kind reports ok
    plan_known(KIND_READ, 5'd0, 32'h0, 32'h0, STAT_EMPTY, 1'b0, 5'd0);
    plan_known(KIND_REMOVE_FRONT, 5'd0, 32'h0, 32'h0, STAT_EMPTY, 1'b0, 5'd0);
    plan_known(KIND_REMOVE_BACK, 5'd0, 32'h0, 32'h0, STAT_EMPTY, 1'b0, 5'd0);
    plan_known(KIND_REMOVE_AT, 5'd31, 32'h0, 32'h0, STAT_EMPTY, 1'b0, 5'd0);
    plan_known(KIND_REMOVE_VALUE, 5'd0, 32'hffff_ffff, 32'h0, STAT_EMPTY, 1'b0, 5'd0);
    plan_known(KIND_CONTAINS, 5'd0, 32'h0, 32'h0, STAT_OK, 1'b0, 5'd0);
    plan_known(4'd15, 5'd31, 32'hffff_ffff, 32'h0, STAT_OK, 1'b0, 5'd0);
    // Build a short list; insert before the last entry and past the end
    plan_known(KIND_ADD_BACK, 5'd0, 32'hffff_ffff, 32'h0, STAT_OK, 1'b0, 5'd1);
    plan_known(KIND_ADD_FRONT, 5'd0, 32'h0, 32'h0, STAT_OK, 1'b0, 5'd2);
    plan_checked(KIND_INSERT_AT, 5'd1, 32'h5a5a_5a5a, 1);
    plan_checked(KIND_INSERT_AT, 5'd31, 32'ha5a5_a5a5, 1);
    plan_known(KIND_READ, 5'd31, 32'h0, 32'h0, STAT_RANGE, 1'b0, 5'd4);
    plan_checked(KIND_READ, 5'd3, 32'h0, 1);
    plan_known(KIND_CONTAINS, 5'd0, 32'h1234_5678, 32'h0, STAT_OK, 1'b0, 5'd4);
    plan_checked(KIND_CONTAINS, 5'd0, 32'hffff_ffff, 1);
    plan_known(KIND_REMOVE_VALUE, 5'd0, 32'h1234_5678, 32'h0, STAT_NOTFOUND, 1'b0, 5'd4);
    // Remove position past the last clamps to the back; then remove from the middle
    plan_checked(KIND_REMOVE_AT, 5'd20, 32'h0, 1);
    plan_checked(KIND_REMOVE_AT, 5'd1, 32'h0, 1);
    // Fill with duplicates, then overflow every insert kind, remove one, insert at the front and empty the list
    plan_checked(KIND_ADD_BACK, 5'd0, 32'h0000_0001, 14);
    plan_known(KIND_INSERT_AT, 5'd0, 32'h7, 32'h0, STAT_FULL, 1'b0, 5'd16);
    plan_known(KIND_ADD_FRONT, 5'd0, 32'h7, 32'h0, STAT_FULL, 1'b0, 5'd16);
    plan_known(KIND_ADD_BACK, 5'd0, 32'h7, 32'h0, STAT_FULL, 1'b0, 5'd16);
    plan_checked(KIND_REMOVE_VALUE, 5'd0, 32'h0000_0001, 1);
    plan_checked(KIND_INSERT_AT, 5'd0, 32'hdead_beef, 1);
    plan_checked(KIND_REMOVE_FRONT, 5'd0, 32'h0, 16);
    plan_known(KIND_REMOVE_BACK, 5'd0, 32'h0, 32'h0, STAT_EMPTY, 1'b0, 5'd0);

    // Hold reset, then release at a rising edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      for (k = 0; k < plan[i].reps; k++)
        issue_request(plan[i].kind, plan[i].pos, plan[i].value, plan[i].known, plan[i].want);

    // Random phases: fill-biased and drain-biased, every third one without idling
    ins_pct = 60;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        quiet = ((n / 100) % 3 == 2);
        ins_pct = ((n / 100) % 2 == 0) ? 60 : 25;
        foreach (word_pool[j]) word_pool[j] = $urandom();
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        kind = 4'($urandom_range(9, 15));
      end else begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) kind = 4'($urandom_range(0, 2));
        else if (r < ins_pct + 15) kind = 4'($urandom_range(7, 8));
        else kind = 4'($urandom_range(3, 6));
      end
      pos = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(0, 31));
      value = $urandom_range(0, 1) ? word_pool[$urandom_range(0, 7)] : 32'($urandom());
      issue_request(kind, pos, value, 1'b0, '{word: '0, status: STAT_OK, found: 1'b0,
                                             count: '0});
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_positional_list_unit");
    end else begin
      $display("FAIL bounded_positional_list_unit");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #4000000;
    $display("FAIL bounded_positional_list_unit");
    $finish;
  end

endmodule
